// File: sv/cac_pkg.sv
// ----------------------------------------------------------------------------
// cac_pkg
// Shared types, codes and constants of the capacitance auto-range counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cac_pkg;

  // Number of charge resistors and the width of the resistor index.
  localparam int RANGE_COUNT = 4;
  localparam int RANGE_W     = $clog2(RANGE_COUNT);

  localparam logic [RANGE_W-1:0] RANGE_MAX = RANGE_W'(RANGE_COUNT - 1);

  // Event codes carried in the mode field.
  localparam logic [3:0] MODE_PULSE      = 4'd0;
  localparam logic [3:0] MODE_PULSE_OVF  = 4'd1;
  localparam logic [3:0] MODE_FREQ_OVF   = 4'd2;
  localparam logic [3:0] MODE_WINDOW     = 4'd3;
  localparam logic [3:0] MODE_POLL       = 4'd4;
  localparam logic [3:0] MODE_START      = 4'd5;
  localparam logic [3:0] MODE_DISCARD    = 4'd6;
  localparam logic [3:0] MODE_PAUSE      = 4'd7;
  localparam logic [3:0] MODE_RESUME     = 4'd8;
  localparam logic [3:0] MODE_STOP       = 4'd9;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIVIDER   = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [7:0] FREQ_LIMIT_RST    = 8'd2;
  localparam logic [7:0] TIMEOUT_LIMIT_RST = 8'd2;
  localparam logic [2:0] MAX_DIVIDER_RST   = 3'd6;

  // Window skip counts used by the commands.
  localparam logic [7:0] SKIP_START = 8'd2;
  localparam logic [7:0] SKIP_ONE   = 8'd1;
  localparam logic [7:0] SKIP_PAUSE = 8'hFF;

  localparam logic [2:0] DIVIDER_MIN = 3'd1;

  typedef struct packed {
    logic [3:0]  mode;
    logic [15:0] pulse_width;
    logic        comparator_high;
    logic [15:0] capture_count;
    logic [7:0]  discard_count;
  } item_t;

  typedef struct packed {
    logic        report_valid;
    logic [23:0] oscillation_count;
    logic [31:0] fall_width_sum;
    logic [1:0]  resistor_index;
    logic [2:0]  divider_code;
    logic [3:0]  filter_samples;
    logic        range_changed;
  } result_t;

  typedef struct packed {
    logic [7:0] freq_problem_limit;
    logic [7:0] timeout_error_limit;
    logic [2:0] max_divider_code;
  } cfg_t;

  // Input filter length for each resistor; only the largest resistor uses four.
  function automatic logic [3:0] filter_len(input logic [RANGE_W-1:0] idx);
    logic [3:0] len;
    if (idx == RANGE_W'(0) || idx == RANGE_W'(1)) begin
      len = 4'd8;
    end else if (idx == RANGE_W'(2)) begin
      len = 4'd6;
    end else begin
      len = 4'd4;
    end
    return len;
  endfunction

endpackage

// File: sv/cac_in_if.sv
// ----------------------------------------------------------------------------
// cac_in_if
// Event request channel with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cac_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mode;
  logic [15:0] pulse_width;
  logic        comparator_high;
  logic [15:0] capture_count;
  logic [7:0]  discard_count;

  modport source (output valid, mode, pulse_width, comparator_high, capture_count,
                  discard_count, input ready);
  modport sink   (input valid, mode, pulse_width, comparator_high, capture_count,
                  discard_count, output ready);
endinterface

// File: sv/cac_out_if.sv
// ----------------------------------------------------------------------------
// cac_out_if
// Result request channel with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cac_out_if;
  logic        valid;
  logic        ready;
  logic        report_valid;
  logic [23:0] oscillation_count;
  logic [31:0] fall_width_sum;
  logic [1:0]  resistor_index;
  logic [2:0]  divider_code;
  logic [3:0]  filter_samples;
  logic        range_changed;

  modport source (output valid, report_valid, oscillation_count, fall_width_sum,
                  resistor_index, divider_code, filter_samples, range_changed,
                  input ready);
  modport sink   (input valid, report_valid, oscillation_count, fall_width_sum,
                  resistor_index, divider_code, filter_samples, range_changed,
                  output ready);
endinterface

// File: sv/cac_cfg_if.sv
// ----------------------------------------------------------------------------
// cac_cfg_if
// Configuration write channel with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cac_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cac_pkg::CFG_IDX_W-1:0]  index;
  logic [7:0]                     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/cac_cfg_regs.sv
// ----------------------------------------------------------------------------
// cac_cfg_regs
// Configuration register file, written through the configuration channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cac_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  cac_cfg_if.sink       cfg_ch,
  output cac_pkg::cfg_t cfg
);

  cac_pkg::cfg_t cfg_r;
  cac_pkg::cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        cac_pkg::CFG_FREQ_LIMIT:    cfg_nxt.freq_problem_limit  = cfg_ch.data;
        cac_pkg::CFG_TIMEOUT_LIMIT: cfg_nxt.timeout_error_limit = cfg_ch.data;
        cac_pkg::CFG_MAX_DIVIDER:   cfg_nxt.max_divider_code    = cfg_ch.data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.freq_problem_limit  <= cac_pkg::FREQ_LIMIT_RST;
      cfg_r.timeout_error_limit <= cac_pkg::TIMEOUT_LIMIT_RST;
      cfg_r.max_divider_code    <= cac_pkg::MAX_DIVIDER_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: sv/cac_core.sv
// ----------------------------------------------------------------------------
// cac_core
// Measurement state and the single-pass event logic that updates it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cac_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  cac_pkg::item_t   item,
  input  cac_pkg::cfg_t    cfg,
  output cac_pkg::result_t result
);

  logic [31:0] sum_run_r, sum_run_nxt;
  logic [31:0] cnt_run_r, cnt_run_nxt;
  logic [31:0] sum_lat_r, sum_lat_nxt;
  logic [31:0] cnt_lat_r, cnt_lat_nxt;
  logic [15:0] prev_cap_r, prev_cap_nxt;
  logic [7:0]  wrap_r, wrap_nxt;
  logic [23:0] osc_lat_r, osc_lat_nxt;
  logic        timeout_r, timeout_nxt;
  logic [cac_pkg::RANGE_W-1:0] range_r, range_nxt;
  logic [2:0]  div_r, div_nxt;
  logic [7:0]  skip_r, skip_nxt;
  logic [7:0]  tstreak_r, tstreak_nxt;
  logic [7:0]  rstreak_r, rstreak_nxt;
  logic        fresh_r, fresh_nxt;

  logic [7:0]  wrap_adj;
  logic [23:0] osc_win;
  logic [31:0] low_bound;
  logic [31:0] high_bound;
  logic        rep_valid;
  logic [cac_pkg::RANGE_W-1:0] show_idx;
  logic [2:0]  show_div;

  assign wrap_adj   = (item.capture_count < prev_cap_r) ? wrap_r - 8'd1 : wrap_r;
  assign osc_win    = {wrap_adj, 16'd0} + {8'd0, item.capture_count} - {8'd0, prev_cap_r};
  assign low_bound  = {cnt_lat_r[24:0], 7'd0};
  assign high_bound = {cnt_lat_r[20:0], 11'd0};

  always_comb begin
    sum_run_nxt  = sum_run_r;
    cnt_run_nxt  = cnt_run_r;
    sum_lat_nxt  = sum_lat_r;
    cnt_lat_nxt  = cnt_lat_r;
    prev_cap_nxt = prev_cap_r;
    wrap_nxt     = wrap_r;
    osc_lat_nxt  = osc_lat_r;
    timeout_nxt  = timeout_r;
    range_nxt    = range_r;
    div_nxt      = div_r;
    skip_nxt     = skip_r;
    tstreak_nxt  = tstreak_r;
    rstreak_nxt  = rstreak_r;
    fresh_nxt    = fresh_r;
    rep_valid    = 1'b0;

    case (item.mode)
      cac_pkg::MODE_PULSE: begin
        if (!item.comparator_high) begin
          sum_run_nxt = sum_run_r + {16'd0, item.pulse_width};
          cnt_run_nxt = cnt_run_r + 32'd1;
        end
      end
      cac_pkg::MODE_PULSE_OVF: timeout_nxt = 1'b1;
      cac_pkg::MODE_FREQ_OVF:  wrap_nxt = wrap_r + 8'd1;
      cac_pkg::MODE_WINDOW: begin
        osc_lat_nxt  = osc_win;
        prev_cap_nxt = item.capture_count;
        sum_lat_nxt  = sum_run_r;
        cnt_lat_nxt  = cnt_run_r;
        sum_run_nxt  = 32'd0;
        cnt_run_nxt  = 32'd0;
        wrap_nxt     = 8'd0;
        if (skip_r == 8'd0) begin
          if (timeout_r) begin
            // Timeouts walk down the resistors, then up the divider, and
            // finally jump two resistors up once the streak passes the limit.
            if (range_r != '0) begin
              range_nxt = range_r - cac_pkg::RANGE_W'(1);
              skip_nxt  = cac_pkg::SKIP_ONE;
            end else if (div_r < cfg.max_divider_code) begin
              div_nxt  = div_r + 3'd1;
              skip_nxt = cac_pkg::SKIP_ONE;
            end else begin
              tstreak_nxt = tstreak_r + 8'd1;
              if (tstreak_r > cfg.timeout_error_limit) begin
                div_nxt   = cac_pkg::DIVIDER_MIN;
                range_nxt = range_r + cac_pkg::RANGE_W'(2);
                skip_nxt  = cac_pkg::SKIP_ONE;
              end
            end
            timeout_nxt = 1'b0;
          end else begin
            fresh_nxt = 1'b1;
          end
        end else begin
          skip_nxt    = skip_r - 8'd1;
          timeout_nxt = 1'b0;
        end
      end
      cac_pkg::MODE_POLL: begin
        if (fresh_r) begin
          rep_valid = 1'b1;
          fresh_nxt = 1'b0;
          if (skip_r == 8'd0) begin
            if (sum_lat_r < low_bound) begin
              // Oscillator too fast: lower the divider, else raise resistor.
              rstreak_nxt = rstreak_r + 8'd1;
              if (rstreak_r > cfg.freq_problem_limit) begin
                if (div_r != cac_pkg::DIVIDER_MIN) begin
                  div_nxt  = div_r - 3'd1;
                  skip_nxt = cac_pkg::SKIP_ONE;
                end else if (range_r < cac_pkg::RANGE_MAX) begin
                  range_nxt = range_r + cac_pkg::RANGE_W'(1);
                  skip_nxt  = cac_pkg::SKIP_ONE;
                end
                rstreak_nxt = 8'd0;
              end
            end else if (sum_lat_r > high_bound && range_r != '0) begin
              rstreak_nxt = rstreak_r + 8'd1;
              if (rstreak_r > cfg.freq_problem_limit) begin
                range_nxt   = range_r - cac_pkg::RANGE_W'(1);
                rstreak_nxt = 8'd0;
              end
            end else begin
              rstreak_nxt = 8'd0;
            end
          end
        end
      end
      cac_pkg::MODE_START: begin
        skip_nxt  = cac_pkg::SKIP_START;
        range_nxt = cac_pkg::RANGE_MAX;
        div_nxt   = cac_pkg::DIVIDER_MIN;
      end
      cac_pkg::MODE_DISCARD: skip_nxt = item.discard_count;
      cac_pkg::MODE_PAUSE:   skip_nxt = cac_pkg::SKIP_PAUSE;
      cac_pkg::MODE_RESUME:  skip_nxt = cac_pkg::SKIP_ONE;
      cac_pkg::MODE_STOP: begin
        sum_run_nxt  = 32'd0;
        cnt_run_nxt  = 32'd0;
        wrap_nxt     = 8'd0;
        prev_cap_nxt = 16'd0;
      end
      default: ;
    endcase
  end

  // A fresh report shows the range it was measured with.
  assign show_idx = rep_valid ? range_r : range_nxt;
  assign show_div = rep_valid ? div_r : div_nxt;

  always_comb begin
    result.report_valid      = rep_valid;
    result.oscillation_count = rep_valid ? osc_lat_r : 24'd0;
    result.fall_width_sum    = rep_valid ? sum_lat_r : 32'd0;
    result.resistor_index    = show_idx[1:0];
    result.divider_code      = show_div;
    result.filter_samples    = cac_pkg::filter_len(show_idx);
    result.range_changed     = (range_nxt != range_r) || (div_nxt != div_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_run_r  <= 32'd0;
      cnt_run_r  <= 32'd0;
      sum_lat_r  <= 32'd0;
      cnt_lat_r  <= 32'd0;
      prev_cap_r <= 16'd0;
      wrap_r     <= 8'd0;
      osc_lat_r  <= 24'd0;
      timeout_r  <= 1'b0;
      range_r    <= cac_pkg::RANGE_MAX;
      div_r      <= cac_pkg::DIVIDER_MIN;
      skip_r     <= cac_pkg::SKIP_START;
      tstreak_r  <= 8'd0;
      rstreak_r  <= 8'd0;
      fresh_r    <= 1'b0;
    end else if (fire) begin
      sum_run_r  <= sum_run_nxt;
      cnt_run_r  <= cnt_run_nxt;
      sum_lat_r  <= sum_lat_nxt;
      cnt_lat_r  <= cnt_lat_nxt;
      prev_cap_r <= prev_cap_nxt;
      wrap_r     <= wrap_nxt;
      osc_lat_r  <= osc_lat_nxt;
      timeout_r  <= timeout_nxt;
      range_r    <= range_nxt;
      div_r      <= div_nxt;
      skip_r     <= skip_nxt;
      tstreak_r  <= tstreak_nxt;
      rstreak_r  <= rstreak_nxt;
      fresh_r    <= fresh_nxt;
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_r != 3'd0)
    else $error("divider code reached zero");

  a_window_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.mode == cac_pkg::MODE_WINDOW && skip_r == 8'd0 && !timeout_r
    |=> fresh_r)
    else $error("clean window did not mark the measurement fresh");

  a_poll_consumes: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.mode == cac_pkg::MODE_POLL |=> !fresh_r)
    else $error("poll left the measurement marked fresh");

  a_report_only_poll: assert property (@(posedge clk) disable iff (!rst_n)
    fire && rep_valid |-> item.mode == cac_pkg::MODE_POLL && fresh_r)
    else $error("report raised outside a fresh poll");

endmodule

// File: sv/cac_out_stage.sv
// ----------------------------------------------------------------------------
// cac_out_stage
// Result register that drives the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cac_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  cac_pkg::result_t result,
  output logic             can_take,
  cac_out_if.source        out_ch
);

  logic             valid_r, valid_nxt;
  cac_pkg::result_t data_r;

  assign can_take  = !valid_r || out_ch.ready;
  assign valid_nxt = load ? 1'b1 : (valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_ch.valid             = valid_r;
  assign out_ch.report_valid      = data_r.report_valid;
  assign out_ch.oscillation_count = data_r.oscillation_count;
  assign out_ch.fall_width_sum    = data_r.fall_width_sum;
  assign out_ch.resistor_index    = data_r.resistor_index;
  assign out_ch.divider_code      = data_r.divider_code;
  assign out_ch.filter_samples    = data_r.filter_samples;
  assign out_ch.range_changed     = data_r.range_changed;

endmodule

// File: sv/capacitance_autorange_counter.sv
// ----------------------------------------------------------------------------
// capacitance_autorange_counter
// Event-driven auto-ranging core of an RC-oscillator capacitance meter.
// ----------------------------------------------------------------------------
// Path: an accepted event request is held in the input register, and its
// result is then captured in the result register that drives the channel.
// Throughput: one event request per cycle while the result channel keeps up;
// the single state update per event is the only loop.
// Reset: synchronous, active low; all measurement state and the
// configuration registers return to their documented defaults at once.
`timescale 1ns / 1ps

module capacitance_autorange_counter (
  input  logic      clk,
  input  logic      rst_n,
  cac_in_if.sink    in_ch,
  cac_out_if.source out_ch,
  cac_cfg_if.sink   cfg_ch
);

  // Input register: holds one accepted event request until the core and the
  // result register can take it. A request advances whenever the result
  // register is empty or being drained, so while the result side keeps up
  // the input stays open every cycle.
  logic             in_valid_r, in_valid_nxt;
  cac_pkg::item_t   in_item_r;
  logic             advance;
  logic             accept;
  logic             can_take;
  cac_pkg::cfg_t    cfg;
  cac_pkg::result_t core_result;

  assign advance      = in_valid_r && can_take;
  assign in_ch.ready  = !in_valid_r || advance;
  assign accept       = in_ch.valid && in_ch.ready;
  assign in_valid_nxt = accept ? 1'b1 : (in_valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item_r.mode            <= in_ch.mode;
      in_item_r.pulse_width     <= in_ch.pulse_width;
      in_item_r.comparator_high <= in_ch.comparator_high;
      in_item_r.capture_count   <= in_ch.capture_count;
      in_item_r.discard_count   <= in_ch.discard_count;
    end
  end

  // The user must write configuration only while no event is in flight; not enforced here.
  cac_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // The core applies the held event to the measurement state in the same
  // cycle that its result is captured by the result register.
  cac_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (in_item_r),
    .cfg    (cfg),
    .result (core_result)
  );

  cac_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (advance),
    .result   (core_result),
    .can_take (can_take),
    .out_ch   (out_ch)
  );

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !can_take |=> in_valid_r)
    else $error("held event request was lost while the result register was full");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> in_ch.ready)
    else $error("input not ready with an empty input register");

  a_advance_loads: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_ch.valid)
    else $error("advanced event produced no result");

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the capacitance auto-range counter: a queue-fed
// request driver, a randomly stalling result sink and a cycle-free predictor
// that checks every result request field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  logic clk;
  logic rst_n;

  cac_in_if  in_ch();
  cac_out_if out_ch();
  cac_cfg_if cfg_ch();

  capacitance_autorange_counter u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // The clock is low for the first half period, so the first rising edge
  // comes at 6 ns.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state. This mirrors the block's measurement state; it is
  // advanced once for every event request the block accepts.
  // --------------------------------------------------------------------------
  logic [31:0]                 fall_sum_run;
  logic [31:0]                 fall_cnt_run;
  logic [31:0]                 fall_sum_win;
  logic [31:0]                 fall_cnt_win;
  logic [15:0]                 last_capture;
  logic [7:0]                  ovf_wraps;
  logic [23:0]                 osc_latched;
  logic                        timeout_seen;
  logic [cac_pkg::RANGE_W-1:0] res_idx;
  logic [2:0]                  div_code;
  logic [7:0]                  skip_left;
  logic [7:0]                  timeout_run;
  logic [7:0]                  rate_run;
  logic                        fresh;

  // Shadow copy of the configuration registers, updated on each accepted
  // configuration write.
  cac_pkg::cfg_t cfg_shadow;

  // Pending event requests for the driver, and the results still owed by
  // the block, oldest first.
  cac_pkg::item_t   pending_q[$];
  cac_pkg::result_t owed_results_q[$];

  int unsigned error_cnt;
  int unsigned queued_cnt;
  int unsigned accepted_cnt;
  int unsigned report_cnt;
  int unsigned change_cnt;
  int unsigned setting_cnt;

  // Handshake flags raised at the rising edge and consumed at the falling one.
  bit               in_taken;
  bit               out_taken;
  bit               in_live;
  bit               in_calm;
  bit               out_calm;
  int unsigned      in_gap;
  int unsigned      out_stall;
  cac_pkg::item_t   seen_ev;
  cac_pkg::result_t want_res;

  task automatic reset_model();
    fall_sum_run = '0;
    fall_cnt_run = '0;
    fall_sum_win = '0;
    fall_cnt_win = '0;
    last_capture = '0;
    ovf_wraps    = '0;
    osc_latched  = '0;
    timeout_seen = 1'b0;
    res_idx      = cac_pkg::RANGE_MAX;
    div_code     = cac_pkg::DIVIDER_MIN;
    skip_left    = cac_pkg::SKIP_START;
    timeout_run  = '0;
    rate_run     = '0;
    fresh        = 1'b0;
    cfg_shadow.freq_problem_limit  = cac_pkg::FREQ_LIMIT_RST;
    cfg_shadow.timeout_error_limit = cac_pkg::TIMEOUT_LIMIT_RST;
    cfg_shadow.max_divider_code    = cac_pkg::MAX_DIVIDER_RST;
  endtask

  // Window end: latch the oscillation count and the pulse statistics, then
  // let a timeout seen during the window move the range. A range move makes
  // the next window a settling window that is thrown away.
  task automatic close_window(input logic [15:0] cap);
    logic [31:0] span;
    bit          over;
    if (cap < last_capture) begin
      ovf_wraps = ovf_wraps - 8'd1;
    end
    span = {8'h00, ovf_wraps, 16'h0000} + {16'h0000, cap} - {16'h0000, last_capture};
    osc_latched  = span[23:0];
    last_capture = cap;
    fall_sum_win = fall_sum_run;
    fall_cnt_win = fall_cnt_run;
    fall_sum_run = '0;
    fall_cnt_run = '0;
    ovf_wraps    = '0;
    if (skip_left == 8'd0) begin
      if (timeout_seen) begin
        if (res_idx != '0) begin
          res_idx   = res_idx - cac_pkg::RANGE_W'(1);
          skip_left = cac_pkg::SKIP_ONE;
        end else if (div_code < cfg_shadow.max_divider_code) begin
          div_code  = div_code + 3'd1;
          skip_left = cac_pkg::SKIP_ONE;
        end else begin
          // The timeout streak counts on every pass here and is never
          // cleared; the jump happens once it has passed the limit.
          over        = timeout_run > cfg_shadow.timeout_error_limit;
          timeout_run = timeout_run + 8'd1;
          if (over) begin
            div_code  = cac_pkg::DIVIDER_MIN;
            res_idx   = res_idx + cac_pkg::RANGE_W'(2);
            skip_left = cac_pkg::SKIP_ONE;
          end
        end
        timeout_seen = 1'b0;
      end else begin
        fresh = 1'b1;
      end
    end else begin
      skip_left    = skip_left - 8'd1;
      timeout_seen = 1'b0;
    end
  endtask

  // Rate check after a fresh report: the average falling width is compared
  // with 2^7 and 2^11 ticks by scaling the pulse count, truncated to 32 bits.
  task automatic judge_rate();
    logic [31:0] low_bound;
    logic [31:0] high_bound;
    bit          over;
    low_bound  = fall_cnt_win << 7;
    high_bound = fall_cnt_win << 11;
    if (skip_left == 8'd0) begin
      if (fall_sum_win < low_bound) begin
        // Oscillator too fast: lower the divider code first, then go to a
        // larger resistor.
        over     = rate_run > cfg_shadow.freq_problem_limit;
        rate_run = rate_run + 8'd1;
        if (over) begin
          if (div_code != cac_pkg::DIVIDER_MIN) begin
            div_code  = div_code - 3'd1;
            skip_left = cac_pkg::SKIP_ONE;
          end else if (res_idx < cac_pkg::RANGE_MAX) begin
            res_idx   = res_idx + cac_pkg::RANGE_W'(1);
            skip_left = cac_pkg::SKIP_ONE;
          end
          rate_run = '0;
        end
      end else if (fall_sum_win > high_bound && res_idx != '0) begin
        // Oscillator too slow: go to a smaller resistor, with no settling
        // window.
        over     = rate_run > cfg_shadow.freq_problem_limit;
        rate_run = rate_run + 8'd1;
        if (over) begin
          res_idx  = res_idx - cac_pkg::RANGE_W'(1);
          rate_run = '0;
        end
      end else begin
        rate_run = '0;
      end
    end
  endtask

  // Advances the predictor by one event and returns the result it owes.
  task automatic predict_event(input cac_pkg::item_t ev, output cac_pkg::result_t res);
    logic [cac_pkg::RANGE_W-1:0] idx_in;
    logic [2:0]                  div_in;
    logic [cac_pkg::RANGE_W-1:0] shown_idx;
    bit                          reported;
    idx_in   = res_idx;
    div_in   = div_code;
    reported = 1'b0;
    res      = '0;
    case (ev.mode)
      cac_pkg::MODE_PULSE: begin
        if (!ev.comparator_high) begin
          fall_sum_run = fall_sum_run + 32'(ev.pulse_width);
          fall_cnt_run = fall_cnt_run + 32'd1;
        end
      end
      cac_pkg::MODE_PULSE_OVF: timeout_seen = 1'b1;
      cac_pkg::MODE_FREQ_OVF:  ovf_wraps = ovf_wraps + 8'd1;
      cac_pkg::MODE_WINDOW:    close_window(ev.capture_count);
      cac_pkg::MODE_POLL: begin
        if (fresh) begin
          reported              = 1'b1;
          res.report_valid      = 1'b1;
          res.oscillation_count = osc_latched;
          res.fall_width_sum    = fall_sum_win;
          judge_rate();
          fresh = 1'b0;
        end
      end
      cac_pkg::MODE_START: begin
        skip_left = cac_pkg::SKIP_START;
        res_idx   = cac_pkg::RANGE_MAX;
        div_code  = cac_pkg::DIVIDER_MIN;
      end
      cac_pkg::MODE_DISCARD: skip_left = ev.discard_count;
      cac_pkg::MODE_PAUSE:   skip_left = cac_pkg::SKIP_PAUSE;
      cac_pkg::MODE_RESUME:  skip_left = cac_pkg::SKIP_ONE;
      cac_pkg::MODE_STOP: begin
        fall_sum_run = '0;
        fall_cnt_run = '0;
        ovf_wraps    = '0;
        last_capture = '0;
      end
      default: ;
    endcase
    // A fresh report shows the range the measurement was taken with; every
    // other event shows the range it leaves behind.
    shown_idx          = reported ? idx_in : res_idx;
    res.resistor_index = shown_idx;
    res.divider_code   = reported ? div_in : div_code;
    case (shown_idx)
      2'd0, 2'd1: res.filter_samples = 4'd8;
      2'd2:       res.filter_samples = 4'd6;
      default:    res.filter_samples = 4'd4;
    endcase
    res.range_changed = (res_idx != idx_in) || (div_code != div_in);
  endtask

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name,
               want, got);
      error_cnt++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Request driver. Inputs change at the falling edge only. After each
  // accepted request it idles for a drawn number of cycles; now and then it
  // switches into a calm stretch where it presents requests back to back.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        in_taken = 1'b0;
        in_live  = 1'b0;
        if ($urandom_range(0, 29) == 0) begin
          in_calm = !in_calm;
        end
        in_gap = in_calm ? 0 : $urandom_range(0, 19);
      end
      if (!in_live) begin
        if (in_gap != 0) begin
          in_gap--;
        end else if (pending_q.size() != 0) begin
          in_ch.mode            <= pending_q[0].mode;
          in_ch.pulse_width     <= pending_q[0].pulse_width;
          in_ch.comparator_high <= pending_q[0].comparator_high;
          in_ch.capture_count   <= pending_q[0].capture_count;
          in_ch.discard_count   <= pending_q[0].discard_count;
          void'(pending_q.pop_front());
          in_live = 1'b1;
        end
      end
      // One assignment per edge keeps valid steady across back-to-back requests.
      in_ch.valid <= in_live;
    end
  end

  // Result sink. The stall is drawn per result and only counts down while a
  // result is waiting, so it always lands on a presented result.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) begin
        out_taken = 1'b0;
        if ($urandom_range(0, 29) == 0) begin
          out_calm = !out_calm;
        end
        out_stall = out_calm ? 0 : $urandom_range(0, 19);
      end
      if (out_stall != 0 && out_ch.valid) begin
        out_stall--;
      end
      out_ch.ready <= (out_stall == 0);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Everything is sampled at the rising edge. The accepted event is
  // predicted before the result of the same edge is checked, so the queue
  // ordering alone decides which expectation a result is matched against.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          cac_pkg::CFG_FREQ_LIMIT:    cfg_shadow.freq_problem_limit  = cfg_ch.data;
          cac_pkg::CFG_TIMEOUT_LIMIT: cfg_shadow.timeout_error_limit = cfg_ch.data;
          cac_pkg::CFG_MAX_DIVIDER:   cfg_shadow.max_divider_code    = cfg_ch.data[2:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        seen_ev.mode            = in_ch.mode;
        seen_ev.pulse_width     = in_ch.pulse_width;
        seen_ev.comparator_high = in_ch.comparator_high;
        seen_ev.capture_count   = in_ch.capture_count;
        seen_ev.discard_count   = in_ch.discard_count;
        predict_event(seen_ev, want_res);
        owed_results_q.push_back(want_res);
        accepted_cnt++;
        in_taken = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        out_taken = 1'b1;
        if (owed_results_q.size() == 0) begin
          $display("%0t ns: result request with none expected, expected none, actual %0h",
                   $time, {out_ch.report_valid, out_ch.oscillation_count,
                   out_ch.fall_width_sum});
          error_cnt++;
        end else begin
          want_res = owed_results_q.pop_front();
          report_field("report_valid", 32'(want_res.report_valid),
                       32'(out_ch.report_valid));
          report_field("oscillation_count", 32'(want_res.oscillation_count),
                       32'(out_ch.oscillation_count));
          report_field("fall_width_sum", want_res.fall_width_sum, out_ch.fall_width_sum);
          report_field("resistor_index", 32'(want_res.resistor_index),
                       32'(out_ch.resistor_index));
          report_field("divider_code", 32'(want_res.divider_code),
                       32'(out_ch.divider_code));
          report_field("filter_samples", 32'(want_res.filter_samples),
                       32'(out_ch.filter_samples));
          report_field("range_changed", 32'(want_res.range_changed),
                       32'(out_ch.range_changed));
          if (want_res.report_valid) begin
            report_cnt++;
          end
          if (want_res.range_changed) begin
            change_cnt++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  function automatic cac_pkg::item_t make_ev(input logic [3:0] m, input logic [15:0] w,
                                             input logic hi, input logic [15:0] cap,
                                             input logic [7:0] disc);
    cac_pkg::item_t ev;
    ev.mode            = m;
    ev.pulse_width     = w;
    ev.comparator_high = hi;
    ev.capture_count   = cap;
    ev.discard_count   = disc;
    return ev;
  endfunction

  // An event of the given kind with every other field random, so that the
  // fields the block should ignore still toggle.
  function automatic cac_pkg::item_t rand_ev(input logic [3:0] m);
    return make_ev(m, 16'($urandom), 1'($urandom), 16'($urandom), 8'($urandom));
  endfunction

  task automatic push_event(input cac_pkg::item_t ev);
    pending_q.push_back(ev);
    // Unused codes are ignored by the block and do not count as stimulus.
    if (ev.mode <= cac_pkg::MODE_STOP) begin
      queued_cnt++;
    end
  endtask

  // One measurement window as the timer hardware would produce it: a burst
  // of pulse captures whose widths sit in one rate band, maybe a counter
  // overflow and maybe a timeout, the window capture and usually a poll. Now and
  // then a command or a malformed request is mixed in.
  task automatic queue_window();
    int unsigned    n_pulses;
    int unsigned    band;
    logic [15:0]    w;
    cac_pkg::item_t ev;
    n_pulses = $urandom_range(0, 8);
    band     = $urandom_range(0, 2);
    for (int i = 0; i < n_pulses; i++) begin
      case (band)
        0:       w = 16'($urandom_range(0, 127));
        1:       w = 16'($urandom_range(128, 2047));
        default: w = 16'($urandom_range(2048, 65535));
      endcase
      ev = rand_ev(cac_pkg::MODE_PULSE);
      ev.pulse_width     = w;
      ev.comparator_high = ($urandom_range(0, 7) == 0);
      push_event(ev);
    end
    if ($urandom_range(0, 3) == 0) begin
      push_event(rand_ev(cac_pkg::MODE_FREQ_OVF));
    end
    if ($urandom_range(0, 4) == 0) begin
      push_event(rand_ev(cac_pkg::MODE_PULSE_OVF));
    end
    push_event(rand_ev(cac_pkg::MODE_WINDOW));
    if ($urandom_range(0, 3) != 0) begin
      push_event(rand_ev(cac_pkg::MODE_POLL));
    end
    case ($urandom_range(0, 19))
      0: push_event(rand_ev(cac_pkg::MODE_START));
      1: push_event(rand_ev(cac_pkg::MODE_STOP));
      2: begin
        push_event(rand_ev(cac_pkg::MODE_PAUSE));
        push_event(rand_ev(cac_pkg::MODE_RESUME));
      end
      3: begin
        ev = rand_ev(cac_pkg::MODE_DISCARD);
        ev.discard_count = 8'($urandom_range(0, 3));
        push_event(ev);
      end
      4, 5: begin
        // Noise: any code with any fields. A long skip is cut short again so
        // that the run does not spend hundreds of windows discarding.
        ev = rand_ev(4'($urandom));
        push_event(ev);
        if (ev.mode == cac_pkg::MODE_PAUSE ||
            (ev.mode == cac_pkg::MODE_DISCARD && ev.discard_count > 8'd4)) begin
          push_event(rand_ev(cac_pkg::MODE_RESUME));
        end
      end
      6: push_event(rand_ev(cac_pkg::MODE_POLL));
      default: ;
    endcase
  endtask

  task automatic write_reg(input logic [cac_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do begin
      @(posedge clk);
    end while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // The block is idle once nothing is queued or presented and every owed
  // result has been taken.
  task automatic wait_drained();
    while (pending_q.size() != 0 || in_ch.valid || owed_results_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] freq_set[5];
    logic [7:0] tmo_set[5];
    logic [2:0] div_set[5];
    int unsigned target;

    // Every block input has a known value from time zero.
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.mode            = cac_pkg::MODE_POLL;
    in_ch.pulse_width     = '0;
    in_ch.comparator_high = 1'b0;
    in_ch.capture_count   = '0;
    in_ch.discard_count   = '0;
    out_ch.ready          = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = cac_pkg::CFG_FREQ_LIMIT;
    cfg_ch.data           = '0;
    error_cnt = 0; queued_cnt = 0; accepted_cnt = 0;
    report_cnt = 0; change_cnt = 0; setting_cnt = 1;
    in_taken = 1'b0; out_taken = 1'b0; in_live = 1'b0;
    in_calm = 1'b0; out_calm = 1'b0; in_gap = 0; out_stall = 0;
    reset_model();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part, run with the reset configuration. Reset leaves two
    // settling windows, so the first fresh report needs a third window.
    push_event(make_ev(cac_pkg::MODE_POLL, 16'h0000, 1'b0, 16'h0000, 8'h00));
    push_event(make_ev(cac_pkg::MODE_PULSE, 16'hFFFF, 1'b0, 16'hFFFF, 8'hFF));
    push_event(make_ev(cac_pkg::MODE_PULSE, 16'h0000, 1'b1, 16'h0000, 8'h00));
    push_event(make_ev(cac_pkg::MODE_PULSE, 16'h0000, 1'b0, 16'h0000, 8'h00));
    push_event(make_ev(cac_pkg::MODE_FREQ_OVF, 16'h0000, 1'b0, 16'h0000, 8'h00));
    push_event(make_ev(cac_pkg::MODE_WINDOW, 16'h0000, 1'b0, 16'hFFFF, 8'h00));
    push_event(make_ev(cac_pkg::MODE_WINDOW, 16'h0000, 1'b0, 16'h0000, 8'h00));
    push_event(make_ev(cac_pkg::MODE_DISCARD, 16'h0000, 1'b0, 16'h0000, 8'h00));
    push_event(make_ev(cac_pkg::MODE_PULSE, 16'd300, 1'b0, 16'h0000, 8'h00));
    push_event(make_ev(cac_pkg::MODE_PULSE, 16'd300, 1'b0, 16'h0000, 8'h00));
    push_event(make_ev(cac_pkg::MODE_FREQ_OVF, 16'h0000, 1'b0, 16'h0000, 8'h00));
    push_event(make_ev(cac_pkg::MODE_WINDOW, 16'h0000, 1'b0, 16'h1000, 8'h00));
    push_event(make_ev(cac_pkg::MODE_POLL, 16'h0000, 1'b0, 16'h0000, 8'h00));
    push_event(make_ev(cac_pkg::MODE_PULSE_OVF, 16'h0000, 1'b0, 16'h0000, 8'h00));
    push_event(make_ev(cac_pkg::MODE_WINDOW, 16'h0000, 1'b0, 16'h2000, 8'h00));
    push_event(make_ev(cac_pkg::MODE_WINDOW, 16'h0000, 1'b0, 16'h3000, 8'h00));
    push_event(make_ev(cac_pkg::MODE_PULSE, 16'd5, 1'b0, 16'h0000, 8'h00));
    push_event(make_ev(cac_pkg::MODE_WINDOW, 16'h0000, 1'b0, 16'h3100, 8'h00));
    push_event(make_ev(cac_pkg::MODE_POLL, 16'h0000, 1'b0, 16'h0000, 8'h00));
    push_event(make_ev(cac_pkg::MODE_PAUSE, 16'h0000, 1'b0, 16'h0000, 8'h00));
    push_event(make_ev(cac_pkg::MODE_RESUME, 16'h0000, 1'b0, 16'h0000, 8'h00));
    push_event(make_ev(cac_pkg::MODE_STOP, 16'h0000, 1'b0, 16'h0000, 8'h00));
    push_event(make_ev(cac_pkg::MODE_START, 16'h0000, 1'b0, 16'h0000, 8'h00));
    push_event(make_ev(4'd10, 16'h0000, 1'b0, 16'h0000, 8'h00));        // unused code
    push_event(make_ev(4'd15, 16'hFFFF, 1'b1, 16'hFFFF, 8'hFF));        // unused code
    push_event(make_ev(cac_pkg::MODE_DISCARD, 16'h0000, 1'b0, 16'h0000, 8'hFF));
    push_event(make_ev(cac_pkg::MODE_RESUME, 16'h0000, 1'b0, 16'h0000, 8'h00));
    wait_drained();

    // Random phases, each under its own configuration. The extremes come
    // first; the divider limit of one follows a phase where the divider
    // could climb to seven, so it starts out above the new limit.
    freq_set = '{8'd0, 8'd255, 8'd1, 8'($urandom), cac_pkg::FREQ_LIMIT_RST};
    tmo_set  = '{8'd0, 8'd255, 8'd1, 8'($urandom), cac_pkg::TIMEOUT_LIMIT_RST};
    div_set  = '{3'd7, 3'd1, 3'd3, 3'($urandom_range(1, 7)), cac_pkg::MAX_DIVIDER_RST};
    for (int p = 0; p < 5; p++) begin
      repeat (4) @(posedge clk);
      write_reg(cac_pkg::CFG_FREQ_LIMIT, freq_set[p]);
      write_reg(cac_pkg::CFG_TIMEOUT_LIMIT, tmo_set[p]);
      write_reg(cac_pkg::CFG_MAX_DIVIDER, {5'd0, div_set[p]});
      setting_cnt++;
      target = queued_cnt + 255;
      while (queued_cnt < target) begin
        queue_window();
      end
      wait_drained();
    end

    // Leave time for any stray result the block might still produce.
    repeat (20) @(posedge clk);
    $display("Run covered %0d event requests under %0d register settings,", accepted_cnt,
             setting_cnt);
    $display("with %0d fresh reports and %0d range changes checked.", report_cnt,
             change_cnt);
    if (error_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
